@@ sv/lsp_pkg.sv @@
// Shared types and codes for the LIFO stack with position access.
// Holds the operation and status codes, the control FSM states and the cell control struct.
// No dependencies.
package lsp_pkg;

  localparam int DEPTH_DEF     = 8;
  localparam int WORD_BITS_DEF = 32;

  localparam logic [2:0] OP_PUSH   = 3'd0;
  localparam logic [2:0] OP_POP    = 3'd1;
  localparam logic [2:0] OP_PRINT  = 3'd2;
  localparam logic [2:0] OP_PEEK   = 3'd3;
  localparam logic [2:0] OP_PEEP   = 3'd4;
  localparam logic [2:0] OP_CHANGE = 3'd5;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_BADPOS = 2'd3;

  typedef enum logic {
    S_IDLE,
    S_PRINT
  } state_t;

  // What a cell loads on the next clock edge.
  typedef enum logic [2:0] {
    C_HOLD,
    C_ABOVE,
    C_BELOW,
    C_LOAD,
    C_WRAP
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     match;
  } cell_ctrl_t;

endpackage

@@ sv/lifo_stack_with_position_access.sv @@
// Top level of the LIFO stack with position access: control FSM, result register, cell chain.
// Depends on lsp_pkg and lsp_cell.
//
//   port group | dir | tdata (low bit up)                | tuser      | tlast
//   s_*        | in  | value[31:0], position[39:32]      | op[2:0]    | -
//   m_*        | out | data[31:0], count[35:32]          | status[1:0]| last
//
// Push, pop, peek, peep and change give one result each. Print gives one result per held
// entry: cell 0 holds the top, and the occupied cells rotate by one toward the top for
// each result, so after the run the stack is back in order.
// Reset (rst, synchronous) empties the stack; the cell words are not cleared.
// A new item is taken only when the FSM is idle and the result register is free or
// being taken; while print runs, input is held off.
module lifo_stack_with_position_access import lsp_pkg::*; #(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // value[31:0], position[39:32]
  input  logic [2:0]  s_tuser,   // op[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // data[31:0], count[35:32], zero fill above
  output logic [1:0]  m_tuser,   // status[1:0]
  output logic        m_tlast
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  state_t state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [CNT_W-1:0] rem, rem_next;

  logic [WORD_BITS-1:0] word [DEPTH];
  logic [WORD_BITS-1:0] rd   [DEPTH];
  cell_ctrl_t           ctrl [DEPTH];

  logic                 slot_free, fire_in;
  logic [2:0]           in_op;
  logic [31:0]          in_value;
  logic [7:0]           in_pos, pos_m1;
  logic [WORD_BITS+31:0] val_x, top_x, rd_x;
  logic [WORD_BITS-1:0] value_w, rd_or;
  logic [31:0]          top32, rd32;
  logic [CNT_W-1:0]     cnt_last;
  logic [CNT_W+3:0]     cnt_x;
  logic                 full, empty, pos_ok;

  logic                 do_push, do_pop, do_rot, do_change, out_load;
  logic [31:0]          res_data;
  logic [1:0]           res_status;
  logic                 res_last;

  assign slot_free = !m_tvalid || m_tready;
  assign s_tready  = (state == S_IDLE) && slot_free;
  assign fire_in   = s_tvalid && s_tready;

  assign in_op    = s_tuser;
  assign in_value = s_tdata[31:0];
  assign in_pos   = s_tdata[39:32];
  assign pos_m1   = in_pos - 8'd1;

  assign val_x   = {{WORD_BITS{1'b0}}, in_value};
  assign value_w = val_x[WORD_BITS-1:0];
  assign top_x   = {32'b0, word[0]};
  assign top32   = top_x[31:0];

  always_comb begin
    rd_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_or = rd_or | rd[i];
    end
  end
  assign rd_x = {32'b0, rd_or};
  assign rd32 = rd_x[31:0];

  assign cnt_last = cnt - CNT_W'(1);
  assign full     = (cnt == CNT_W'(DEPTH));
  assign empty    = (cnt == '0);
  assign pos_ok   = (in_pos != 8'd0) && ({1'b0, in_pos} <= 9'(cnt));

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (fire_in && in_op == OP_PRINT && !empty && cnt != CNT_W'(1)) begin
          state_next = S_PRINT;
        end
      end
      S_PRINT: begin
        if (slot_free && rem == CNT_W'(1)) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath controls and the result for this cycle.
  always_comb begin
    do_push    = 1'b0;
    do_pop     = 1'b0;
    do_rot     = 1'b0;
    do_change  = 1'b0;
    out_load   = 1'b0;
    res_data   = '0;
    res_status = ST_OK;
    res_last   = 1'b1;
    cnt_next   = cnt;
    rem_next   = rem;
    unique case (state)
      S_IDLE: begin
        if (fire_in) begin
          case (in_op) inside
            OP_PUSH: begin
              out_load = 1'b1;
              if (full) begin
                res_status = ST_FULL;
              end else begin
                do_push  = 1'b1;
                cnt_next = cnt + CNT_W'(1);
              end
            end
            OP_POP: begin
              out_load = 1'b1;
              if (empty) begin
                res_status = ST_EMPTY;
              end else begin
                do_pop   = 1'b1;
                res_data = top32;
                cnt_next = cnt_last;
              end
            end
            OP_PRINT: begin
              out_load = 1'b1;
              if (empty) begin
                res_status = ST_EMPTY;
              end else begin
                do_rot   = 1'b1;
                res_data = top32;
                res_last = (cnt == CNT_W'(1));
                rem_next = cnt_last;
              end
            end
            OP_PEEK: begin
              out_load = 1'b1;
              if (empty) begin
                res_status = ST_EMPTY;
              end else begin
                res_data = top32;
              end
            end
            OP_PEEP, OP_CHANGE: begin
              out_load = 1'b1;
              if (!pos_ok) begin
                res_status = ST_BADPOS;
              end else if (in_op == OP_PEEP) begin
                res_data = rd32;
              end else begin
                do_change = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_PRINT: begin
        if (slot_free) begin
          out_load = 1'b1;
          do_rot   = 1'b1;
          res_data = top32;
          res_last = (rem == CNT_W'(1));
          rem_next = rem - CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  // Per-cell control. A rotation covers only the occupied cells.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ctrl[i].match = (8'(i) == pos_m1);
      ctrl[i].op    = C_HOLD;
      if (do_push) begin
        ctrl[i].op = C_ABOVE;
      end else if (do_pop) begin
        ctrl[i].op = C_BELOW;
      end else if (do_rot) begin
        if (CNT_W'(i) < cnt_last) begin
          ctrl[i].op = C_BELOW;
        end else if (CNT_W'(i) == cnt_last) begin
          ctrl[i].op = C_WRAP;
        end
      end else if (do_change && ctrl[i].match) begin
        ctrl[i].op = C_LOAD;
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    lsp_cell #(
      .WORD_BITS (WORD_BITS)
    ) u_cell (
      .clk   (clk),
      .ctrl  (ctrl[g]),
      .above ((g == 0) ? value_w : word[(g == 0) ? 0 : g - 1]),
      .below (word[(g == DEPTH - 1) ? g : g + 1]),
      .wrap  (word[0]),
      .value (value_w),
      .word  (word[g]),
      .rd    (rd[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      rem   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      rem   <= rem_next;
    end
  end

  assign cnt_x = {4'b0, cnt_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {4'b0, cnt_x[3:0], res_data};
      m_tuser <= res_status;
      m_tlast <= res_last;
    end
  end

  // The fill count never passes the depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  // Input is held off for the whole print run.
  a_print_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == S_PRINT) |-> !s_tready)
    else $error("input taken during print");

  // During print the remaining count stays at least one and below the fill count.
  a_print_rem: assert property (@(posedge clk) disable iff (rst)
    (state == S_PRINT) |-> (rem != '0 && rem < cnt))
    else $error("print run count out of range");

  // A full status is only shown while the stack is full.
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ST_FULL) |-> full)
    else $error("full status on a stack that is not full");

endmodule

@@ sv/lsp_cell.sv @@
// One stack cell: a single word register that trades data with its neighbors.
// Depends on lsp_pkg for the cell control struct.
module lsp_cell import lsp_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                 clk,
  input  cell_ctrl_t           ctrl,
  input  logic [WORD_BITS-1:0] above,
  input  logic [WORD_BITS-1:0] below,
  input  logic [WORD_BITS-1:0] wrap,
  input  logic [WORD_BITS-1:0] value,
  output logic [WORD_BITS-1:0] word,
  output logic [WORD_BITS-1:0] rd
);

  always_ff @(posedge clk) begin
    case (ctrl.op)
      C_ABOVE: word <= above;
      C_BELOW: word <= below;
      C_LOAD:  word <= value;
      C_WRAP:  word <= wrap;
      default: ;
    endcase
  end

  // Only the addressed cell drives the shared read bus.
  assign rd = ctrl.match ? word : '0;

endmodule

@@ test/lifo_stack_result_check.sv @@
// Result checker for the LIFO stack with position access: watches both stream channels,
// keeps its own copy of the stack, and compares every result item with the prediction.
// Depends on lsp_pkg for the operation and status codes.
`timescale 1ns / 1ps

module lifo_stack_result_check import lsp_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,   // value[31:0], position[39:32]
  input  logic [2:0]  s_tuser,   // op[2:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,   // data[31:0], count[35:32], zero fill above
  input  logic [1:0]  m_tuser,   // status[1:0]
  input  logic        m_tlast,
  output int          errors,
  output int          pending
);

  typedef struct {
    logic [31:0] data;
    logic [1:0]  status;
    logic [3:0]  count;
    logic        last;
  } stack_result_t;

  stack_result_t awaited[$];
  logic [31:0]   words[DEPTH];
  int            held = 0;
  int            mismatches = 0;
  int            queued = 0;

  assign errors  = mismatches;
  assign pending = queued;

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatches++;
  endtask

  // The count field always reflects the fill level after the request is applied.
  task automatic add_result(input logic [31:0] data, input logic [1:0] status,
                            input logic last);
    stack_result_t r;
    r.data   = data;
    r.status = status;
    r.count  = 4'(held);
    r.last   = last;
    awaited.push_back(r);
  endtask

  task automatic predict_request(input logic [2:0] op, input logic [31:0] word,
                                 input logic [7:0] pos);
    int idx;
    case (op)
      OP_PUSH: begin
        if (held >= DEPTH) begin
          add_result('0, ST_FULL, 1'b1);
        end else begin
          words[held] = word;
          held++;
          add_result('0, ST_OK, 1'b1);
        end
      end
      OP_POP: begin
        if (held == 0) begin
          add_result('0, ST_EMPTY, 1'b1);
        end else begin
          held--;
          add_result(words[held], ST_OK, 1'b1);
        end
      end
      OP_PRINT: begin
        if (held == 0) begin
          add_result('0, ST_EMPTY, 1'b1);
        end else begin
          for (int k = 0; k < held; k++)
            add_result(words[held - 1 - k], ST_OK, k == held - 1);
        end
      end
      OP_PEEK: begin
        if (held == 0) add_result('0, ST_EMPTY, 1'b1);
        else add_result(words[held - 1], ST_OK, 1'b1);
      end
      OP_PEEP, OP_CHANGE: begin
        // Position counts from the top, starting at one; anything outside the
        // held entries is refused without touching the stack.
        if (pos < 1 || pos > held) begin
          add_result('0, ST_BADPOS, 1'b1);
        end else begin
          idx = held - pos;
          if (op == OP_PEEP) begin
            add_result(words[idx], ST_OK, 1'b1);
          end else begin
            words[idx] = word;
            add_result('0, ST_OK, 1'b1);
          end
        end
      end
      default: ;  // The two spare codes are dropped with no result.
    endcase
  endtask

  always @(posedge clk) begin : watch
    stack_result_t due;
    if (rst) begin
      held = 0;
      awaited.delete();
    end else begin
      // A request is predicted before the result check so that the queue stays in order.
      if (s_tvalid && s_tready)
        predict_request(s_tuser, s_tdata[31:0], s_tdata[39:32]);
      if (m_tvalid && m_tready) begin
        if (awaited.size() == 0) begin
          report_mismatch($sformatf("unexpected result data=%0h status=%0d count=%0d last=%0b",
                                    m_tdata[31:0], m_tuser, m_tdata[35:32], m_tlast));
        end else begin
          due = awaited.pop_front();
          if (m_tdata[31:0] !== due.data)
            report_mismatch($sformatf("data %0h, predicted %0h", m_tdata[31:0], due.data));
          if (m_tuser !== due.status)
            report_mismatch($sformatf("status %0d, predicted %0d", m_tuser, due.status));
          if (m_tdata[35:32] !== due.count)
            report_mismatch($sformatf("count %0d, predicted %0d", m_tdata[35:32], due.count));
          if (m_tlast !== due.last)
            report_mismatch($sformatf("last %0b, predicted %0b", m_tlast, due.last));
          if (m_tdata[39:36] !== 4'd0)
            report_mismatch($sformatf("fill bits %0h are not zero", m_tdata[39:36]));
        end
      end
    end
    queued = awaited.size();
  end

endmodule

@@ test/lifo_stack_with_position_access_tb.sv @@
// Top of the testbench for the LIFO stack with position access: clock, reset, request
// stimulus, receiver back-pressure and the final verdict.
// Depends on lsp_pkg, lifo_stack_with_position_access and lifo_stack_result_check.
`timescale 1ns / 1ps

module lifo_stack_with_position_access_tb;
  import lsp_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam int RANDOM_ITEMS = 140;

  // Operation codes the block must ignore.
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_MOSTLY,
    RX_HOLD
  } rx_mode_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // value[31:0], position[39:32]
  logic [2:0]  s_tuser = '0;   // op[2:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // data[31:0], count[35:32], zero fill above
  logic [1:0]  m_tuser;        // status[1:0]
  logic        m_tlast;

  int       errors;
  int       pending;
  int       burst_left = 0;
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_span = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  lifo_stack_with_position_access #(
    .DEPTH    (DEPTH),
    .WORD_BITS(WORD_BITS_DEF)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  lifo_stack_result_check #(
    .DEPTH(DEPTH)
  ) u_result_check (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast),
    .errors  (errors),
    .pending (pending)
  );

  // The receiver switches between open, random, mostly open and fully stalled stretches.
  always @(posedge clk) begin
    if (rx_span == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_span <= $urandom_range(4, 32);
    end else begin
      rx_span <= rx_span - 1;
    end
    case (rx_mode)
      RX_OPEN:   m_tready <= 1'b1;
      RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
      RX_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
      default:   m_tready <= 1'b0;
    endcase
  end

  // Called at a rising edge; returns at the edge where the item was taken.
  task automatic send_request(input logic [2:0] op, input logic [31:0] word,
                              input logic [7:0] pos);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {pos, word};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  initial begin : stimulus
    int       sent;
    int       pick;
    int       push_cut;
    int       pop_cut;
    logic [2:0]  op;
    logic [31:0] word;
    logic [7:0]  pos;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Empty stack: every read is refused, and the spare codes must vanish.
    send_request(OP_PRINT, '0, 8'd0);
    send_request(OP_POP, '0, 8'd0);
    send_request(OP_PEEK, '0, 8'd0);
    send_request(OP_PEEP, '0, 8'd1);
    send_request(OP_CHANGE, 32'h1111_1111, 8'd1);
    send_request(OP_SPARE_LO, 32'hffff_ffff, 8'hff);
    send_request(OP_SPARE_HI, 32'hffff_ffff, 8'hff);

    // Fill to the brim with the word extremes, then one push too many.
    send_request(OP_PUSH, 32'h8000_0000, 8'd0);
    send_request(OP_PUSH, 32'h7fff_ffff, 8'd0);
    send_request(OP_PUSH, 32'h0000_0000, 8'd0);
    send_request(OP_PUSH, 32'hffff_ffff, 8'd0);
    send_request(OP_PUSH, 32'h0000_0001, 8'd0);
    send_request(OP_PUSH, 32'h5a5a_5a5a, 8'd0);
    send_request(OP_PUSH, 32'ha5a5_a5a5, 8'd0);
    send_request(OP_PUSH, 32'h1234_5678, 8'd0);
    send_request(OP_PUSH, 32'hdead_beef, 8'd0);

    // Positions at both ends of the stack and just outside it.
    send_request(OP_PEEP, '0, 8'd1);
    send_request(OP_PEEP, '0, 8'(DEPTH));
    send_request(OP_PEEP, '0, 8'(DEPTH + 1));
    send_request(OP_PEEP, '0, 8'd0);
    send_request(OP_CHANGE, 32'h0bad_f00d, 8'(DEPTH));
    send_request(OP_CHANGE, 32'hcafe_0000, 8'hff);
    send_request(OP_PEEK, '0, 8'd0);
    send_request(OP_PRINT, '0, 8'd0);
    send_request(OP_POP, '0, 8'd0);

    // Random part: phases that lean toward filling alternate with phases that drain.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      push_cut = ((sent / 20) % 2 == 0) ? 50 : 20;
      pop_cut  = push_cut + (((sent / 20) % 2 == 0) ? 10 : 35);
      pick = $urandom_range(0, 99);
      if (pick < push_cut)     op = OP_PUSH;
      else if (pick < pop_cut) op = OP_POP;
      else if (pick < 62)      op = OP_PRINT;
      else if (pick < 70)      op = OP_PEEK;
      else if (pick < 83)      op = OP_PEEP;
      else if (pick < 95)      op = OP_CHANGE;
      else if (pick < 97)      op = OP_SPARE_LO;
      else                     op = OP_SPARE_HI;
      case ($urandom_range(0, 7))
        0:       word = 32'h8000_0000;
        1:       word = 32'h7fff_ffff;
        2:       word = 32'hffff_ffff;
        3:       word = 32'h0000_0000;
        default: word = $urandom;
      endcase
      if ($urandom_range(0, 4) == 0) pos = 8'($urandom_range(0, 255));
      else pos = 8'($urandom_range(0, DEPTH + 1));
      send_request(op, word, pos);
      if (op != OP_SPARE_LO && op != OP_SPARE_HI) sent++;
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // A trailing spare code gives no result, so allow a full print length of quiet time.
    repeat (3 * DEPTH) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
